// File: hw/rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  localparam logic [1:0] STAT_LOADED    = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EXTRACTED = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic        last_of_load;
    logic [15:0] patient_id;
    logic [7:0]  age;
    logic [15:0] urgency;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_age;
    logic [15:0] out_urgency;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
    logic [15:0] urg;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXT_LD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_REB_NEXT,
    S_REB_LD
  } state_t;

endpackage

// File: hw/rtl/mhpq_ram.sv
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int DATA_W = 40,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: hw/rtl/max_heap_priority_queue_unit.sv
// Binary max-heap priority queue keyed on urgency.
// Input channel: in_word is taken at a rising edge with start high and busy low.
//   A load appends (patient_id, age, urgency); a load with last_of_load set
//   then rebuilds heap order bottom-up. An extract returns the root record.
// Result channel: every accepted word gives exactly one result word on out_word,
//   marked by out_valid for one cycle; the receiver cannot stall it.
// Steps, set by the single heap memory (two read ports, one write port,
// registered read) and the read/compare state loop of a sift:
//   load without rebuild, empty extract: result in the cycle after accept,
//     busy stays low.
//   extract: reads root and last entry, moves the last entry to the root
//     and sifts it down; the result shows when it stops sinking.
//   load with rebuild: each inner node, last first, is loaded and sifted down.
// The next word is accepted in the cycle its predecessor's result shows.
// Reset clears the entry count and the controller; the heap memory is not
// cleared, as only entries below the count are ever used.
`timescale 1ns / 1ps

module max_heap_priority_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mhpq_pkg::in_word_t  in_word,
  output logic                out_valid,
  output mhpq_pkg::out_word_t out_word
);

  import mhpq_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] reb_i_r, reb_i_nxt;
  logic [ADDR_W-1:0] node_r, node_nxt;
  rec_t             cur_r, cur_nxt;
  rec_t             top_r, top_nxt;
  logic             mode_ext_r, mode_ext_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  rec_t              mem_wdata;
  logic [ADDR_W-1:0] mem_raddr0, mem_raddr1;
  logic [REC_W-1:0]  mem_rdata0, mem_rdata1;

  logic [IDX_W-1:0] l_idx, r_idx, cnt_ext;
  logic             l_ok, r_ok, sel_l, sel_r;
  rec_t             rec_l, rec_r;
  logic [15:0]      best_urg;
  logic             has_room;
  logic [CNT_W-1:0] load_cnt, last_cnt, reb_idx;
  logic [1:0]       load_stat;

  mhpq_ram #(
    .DATA_W(REC_W),
    .DEPTH (CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr0(mem_raddr0),
    .raddr1(mem_raddr1),
    .rdata0(mem_rdata0),
    .rdata1(mem_rdata1)
  );

  assign l_idx   = {1'b0, node_r, 1'b1};
  assign r_idx   = l_idx + IDX_W'(1);
  assign cnt_ext = IDX_W'(count_r);
  assign l_ok    = l_idx < cnt_ext;
  assign r_ok    = r_idx < cnt_ext;
  assign rec_l   = rec_t'(mem_rdata0);
  assign rec_r   = rec_t'(mem_rdata1);
  assign sel_l    = l_ok && (rec_l.urg > cur_r.urg);
  assign best_urg = sel_l ? rec_l.urg : cur_r.urg;
  assign sel_r    = r_ok && (rec_r.urg > best_urg);

  assign has_room  = count_r < CNT_W'(CAPACITY);
  assign load_cnt  = has_room ? count_r + CNT_W'(1) : count_r;
  assign load_stat = has_room ? STAT_LOADED : STAT_FULL;
  assign last_cnt  = count_r - CNT_W'(1);
  assign reb_idx   = reb_i_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reb_i_r    <= reb_i_nxt;
    node_r     <= node_nxt;
    cur_r      <= cur_nxt;
    top_r      <= top_nxt;
    mode_ext_r <= mode_ext_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    reb_i_nxt     = reb_i_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    top_nxt       = top_r;
    mode_ext_nxt  = mode_ext_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = cur_r;
    mem_raddr0    = l_idx[ADDR_W-1:0];
    mem_raddr1    = r_idx[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.req_type == REQ_LOAD) begin
            mem_we        = has_room;
            mem_waddr     = count_r[ADDR_W-1:0];
            mem_wdata.id  = in_word.patient_id;
            mem_wdata.age = in_word.age;
            mem_wdata.urg = in_word.urgency;
            count_nxt     = load_cnt;
            status_nxt    = load_stat;
            if (in_word.last_of_load) begin
              reb_i_nxt = load_cnt >> 1;
              state_nxt = S_REB_NEXT;
            end else begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: load_stat, default: '0};
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: STAT_EMPTY, default: '0};
          end else begin
            mem_raddr0 = '0;
            mem_raddr1 = last_cnt[ADDR_W-1:0];
            state_nxt  = S_EXT_LD;
          end
        end
      end
      S_EXT_LD: begin
        top_nxt      = rec_t'(mem_rdata0);
        cur_nxt      = rec_t'(mem_rdata1);
        count_nxt    = last_cnt;
        node_nxt     = '0;
        mode_ext_nxt = 1'b1;
        state_nxt    = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        state_nxt = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        mem_we = 1'b1;
        priority if (sel_r) begin
          mem_wdata = rec_r;
          node_nxt  = r_idx[ADDR_W-1:0];
          state_nxt = S_SIFT_RD;
        end else if (sel_l) begin
          mem_wdata = rec_l;
          node_nxt  = l_idx[ADDR_W-1:0];
          state_nxt = S_SIFT_RD;
        end else if (mode_ext_r) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: STAT_EXTRACTED, out_id: top_r.id,
                            out_age: top_r.age, out_urgency: top_r.urg};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_REB_NEXT;
        end
      end
      S_REB_NEXT: begin
        if (reb_i_r == '0) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: status_r, default: '0};
          state_nxt     = S_IDLE;
        end else begin
          mem_raddr0   = reb_idx[ADDR_W-1:0];
          node_nxt     = reb_idx[ADDR_W-1:0];
          reb_i_nxt    = reb_idx;
          mode_ext_nxt = 1'b0;
          state_nxt    = S_REB_LD;
        end
      end
      S_REB_LD: begin
        cur_nxt   = rec_t'(mem_rdata0);
        state_nxt = S_SIFT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: hw/rtl/mhpq_chk.sv
`timescale 1ns / 1ps

module mhpq_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input mhpq_pkg::in_word_t  in_word,
  input logic                out_valid,
  input mhpq_pkg::out_word_t out_word
);

  import mhpq_pkg::*;

  a_busy_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.req_type == REQ_LOAD) && !in_word.last_of_load
    |=> out_valid && ((out_word.status == STAT_LOADED) ||
                      (out_word.status == STAT_FULL)))
    else $error("plain load did not answer in the next cycle");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != STAT_EXTRACTED)
    |-> (out_word.out_id == '0) && (out_word.out_age == '0) &&
        (out_word.out_urgency == '0))
    else $error("non-extract result carries a record");

endmodule

bind max_heap_priority_queue_unit mhpq_chk u_chk (.*);
